// ===== design/ccimp_pkg.sv =====
// Shared widths, constants and the pipeline sideband type for the circle collision impulse block.
package ccimp_pkg;

    localparam int POS_W  = 24;
    localparam int VEL_W  = 16;
    localparam int RAD_W  = 16;
    localparam int MASS_W = 16;
    localparam int REST_W = 9;

    localparam int DIFF_W  = POS_W + 1;
    localparam int RV_W    = VEL_W + 1;
    localparam int SUM_W   = RAD_W + 1;
    localparam int MSUM_W  = MASS_W + 1;
    localparam int OVL_W   = SUM_W + 1;
    localparam int ABS_W   = SUM_W;
    localparam int SQ_W    = 2 * POS_W + 1;
    localparam int SQP_W   = 2 * DIFF_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int RSQ_W   = 2 * SUM_W;
    localparam int KP_W    = RV_W + OVL_W;
    localparam int K_W     = KP_W + 1;
    localparam int EP_W    = REST_W + 1;
    localparam int KMAG_W  = KP_W;
    localparam int G_W     = EP_W + KMAG_W;
    localparam int P_W     = G_W + ABS_W;
    localparam int Q1_W    = 27;
    localparam int P2_W    = Q1_W + MASS_W;
    localparam int DEN2_W  = MSUM_W + 8;
    localparam int Q2_W    = 19;
    localparam int UPD_W   = Q2_W + 2;

    localparam logic [REST_W-1:0]       REST_RESET = 9'd256;
    localparam logic [EP_W-1:0]         ONE_Q8     = 10'd256;
    localparam logic signed [UPD_W-1:0] VEL_HI     = 21'sd32767;
    localparam logic signed [UPD_W-1:0] VEL_LO     = -21'sd32768;

    typedef struct packed {
        logic signed [VEL_W-1:0] avx;
        logic signed [VEL_W-1:0] avy;
        logic signed [VEL_W-1:0] bvx;
        logic signed [VEL_W-1:0] bvy;
        logic [MASS_W-1:0]       am;
        logic [MASS_W-1:0]       bm;
        logic [MSUM_W-1:0]       msum;
        logic                    sgn_x;
        logic                    sgn_y;
        logic                    ovl;
        logic                    app;
    } tag_t;

endpackage

// ===== design/circle_collision_impulse_top.sv =====
// Top level of the two-circle impulse collision response pipeline.
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// request  | start / busy         | a_*, b_* position, velocity, radius, mass
// result   | done (one cycle)     | a_new_vel_*, b_new_vel_*, overlapping, impulse_applied
// config   | cfg_we               | cfg_wdata (restitution, Q1.8)
//
// One pair per cycle: 5 geometry stages, a 27-stage
// divide by the squared distance, one mass-product stage, a 19-stage divide by the
// mass sum and one saturation stage. busy is always low; the pipeline never stalls
// because results cannot be held off. Reset clears the valid bits and sets
// restitution to 1.0.
module circle_collision_impulse_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ccimp_pkg::POS_W-1:0] a_pos_x,
    input  logic signed [ccimp_pkg::POS_W-1:0] a_pos_y,
    input  logic signed [ccimp_pkg::VEL_W-1:0] a_vel_x,
    input  logic signed [ccimp_pkg::VEL_W-1:0] a_vel_y,
    input  logic [ccimp_pkg::RAD_W-1:0]        a_radius,
    input  logic [ccimp_pkg::MASS_W-1:0]       a_mass,
    input  logic signed [ccimp_pkg::POS_W-1:0] b_pos_x,
    input  logic signed [ccimp_pkg::POS_W-1:0] b_pos_y,
    input  logic signed [ccimp_pkg::VEL_W-1:0] b_vel_x,
    input  logic signed [ccimp_pkg::VEL_W-1:0] b_vel_y,
    input  logic [ccimp_pkg::RAD_W-1:0]        b_radius,
    input  logic [ccimp_pkg::MASS_W-1:0]       b_mass,
    input  logic                               cfg_we,
    input  logic [ccimp_pkg::REST_W-1:0]       cfg_wdata,
    output logic                               done,
    output logic signed [ccimp_pkg::VEL_W-1:0] a_new_vel_x,
    output logic signed [ccimp_pkg::VEL_W-1:0] a_new_vel_y,
    output logic signed [ccimp_pkg::VEL_W-1:0] b_new_vel_x,
    output logic signed [ccimp_pkg::VEL_W-1:0] b_new_vel_y,
    output logic                               overlapping,
    output logic                               impulse_applied
);

    localparam int TAG_W = $bits(ccimp_pkg::tag_t);

    logic [ccimp_pkg::REST_W-1:0] rest_reg;

    logic                          g_valid;
    logic [ccimp_pkg::P_W-1:0]     g_num_x, g_num_y;
    logic [ccimp_pkg::RSQ_W-1:0]   g_den;
    ccimp_pkg::tag_t               g_tag;

    logic [ccimp_pkg::P_W-1:0]     d1_num [2];
    logic                          d1_valid;
    logic [ccimp_pkg::Q1_W-1:0]    d1_quo [2];
    logic [TAG_W-1:0]              d1_tag_vec;
    ccimp_pkg::tag_t               d1_tag;

    logic                          mid_valid_reg;
    logic [ccimp_pkg::P2_W-1:0]    mid_num_reg [4];
    logic [ccimp_pkg::DEN2_W-1:0]  mid_den_reg;
    ccimp_pkg::tag_t               mid_tag_reg;

    logic                          d2_valid;
    logic [ccimp_pkg::Q2_W-1:0]    d2_quo [4];
    logic [TAG_W-1:0]              d2_tag_vec;
    ccimp_pkg::tag_t               d2_tag;

    logic                          done_reg;
    logic signed [ccimp_pkg::VEL_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [ccimp_pkg::VEL_W-1:0] ax_next, ay_next, bx_next, by_next;
    logic                          ovl_reg, app_reg;

    function automatic logic signed [ccimp_pkg::VEL_W-1:0] vel_update(
        input logic signed [ccimp_pkg::VEL_W-1:0] v,
        input logic [ccimp_pkg::Q2_W-1:0]         q,
        input logic                               neg
    );
        logic signed [ccimp_pkg::UPD_W-1:0] d;
        logic signed [ccimp_pkg::UPD_W-1:0] s;
        d = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        s = ccimp_pkg::UPD_W'(v) + d;
        if (s > ccimp_pkg::VEL_HI)
        begin
            return ccimp_pkg::VEL_HI[ccimp_pkg::VEL_W-1:0];
        end
        else if (s < ccimp_pkg::VEL_LO)
        begin
            return ccimp_pkg::VEL_LO[ccimp_pkg::VEL_W-1:0];
        end
        return s[ccimp_pkg::VEL_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= ccimp_pkg::REST_RESET;
        end
        else if (cfg_we)
        begin
            rest_reg <= cfg_wdata;
        end
    end

    ccimp_geom u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .a_pos_x     (a_pos_x),
        .a_pos_y     (a_pos_y),
        .a_vel_x     (a_vel_x),
        .a_vel_y     (a_vel_y),
        .a_radius    (a_radius),
        .a_mass      (a_mass),
        .b_pos_x     (b_pos_x),
        .b_pos_y     (b_pos_y),
        .b_vel_x     (b_vel_x),
        .b_vel_y     (b_vel_y),
        .b_radius    (b_radius),
        .b_mass      (b_mass),
        .restitution (rest_reg),
        .out_valid   (g_valid),
        .num_x       (g_num_x),
        .num_y       (g_num_y),
        .den         (g_den),
        .tag         (g_tag)
    );

    assign d1_num[0] = g_num_x;
    assign d1_num[1] = g_num_y;

    ccimp_div #(
        .NUM_W (ccimp_pkg::P_W),
        .DEN_W (ccimp_pkg::RSQ_W),
        .QUO_W (ccimp_pkg::Q1_W),
        .LANES (2),
        .TAG_W (TAG_W)
    ) u_div_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .num       (d1_num),
        .den       (g_den),
        .tag       (g_tag),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .out_tag   (d1_tag_vec)
    );

    assign d1_tag = d1_tag_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= d1_valid;
            done_reg      <= d2_valid;
        end
    end

    // body a scales by the other mass, body b by its partner's
    always_ff @(posedge clk)
    begin
        mid_num_reg[0] <= d1_quo[0] * d1_tag.bm;
        mid_num_reg[1] <= d1_quo[1] * d1_tag.bm;
        mid_num_reg[2] <= d1_quo[0] * d1_tag.am;
        mid_num_reg[3] <= d1_quo[1] * d1_tag.am;
        mid_den_reg    <= {d1_tag.msum, 8'b0};
        mid_tag_reg    <= d1_tag;
    end

    ccimp_div #(
        .NUM_W (ccimp_pkg::P2_W),
        .DEN_W (ccimp_pkg::DEN2_W),
        .QUO_W (ccimp_pkg::Q2_W),
        .LANES (4),
        .TAG_W (TAG_W)
    ) u_div_mass (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid_reg),
        .num       (mid_num_reg),
        .den       (mid_den_reg),
        .tag       (mid_tag_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .out_tag   (d2_tag_vec)
    );

    assign d2_tag = d2_tag_vec;

    always_comb
    begin
        if (d2_tag.app)
        begin
            ax_next = vel_update(d2_tag.avx, d2_quo[0], d2_tag.sgn_x);
            ay_next = vel_update(d2_tag.avy, d2_quo[1], d2_tag.sgn_y);
            bx_next = vel_update(d2_tag.bvx, d2_quo[2], ~d2_tag.sgn_x);
            by_next = vel_update(d2_tag.bvy, d2_quo[3], ~d2_tag.sgn_y);
        end
        else
        begin
            ax_next = d2_tag.avx;
            ay_next = d2_tag.avy;
            bx_next = d2_tag.bvx;
            by_next = d2_tag.bvy;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        bx_reg  <= bx_next;
        by_reg  <= by_next;
        ovl_reg <= d2_tag.ovl;
        app_reg <= d2_tag.app;
    end

    assign busy            = 1'b0;
    assign done            = done_reg;
    assign a_new_vel_x     = ax_reg;
    assign a_new_vel_y     = ay_reg;
    assign b_new_vel_x     = bx_reg;
    assign b_new_vel_y     = by_reg;
    assign overlapping     = ovl_reg;
    assign impulse_applied = app_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid |=> done)
        else $error("result transfer lost at output stage");

    a_no_extra_done: assert property (@(posedge clk) disable iff (!rst_n)
        !d2_valid |=> !done)
        else $error("result strobe without a pending item");

    a_mid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid |=> mid_valid_reg)
        else $error("item lost between divider stages");

    a_app_ovl_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && impulse_applied |-> overlapping)
        else $error("impulse reported without overlap");

endmodule

// ===== design/ccimp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
module ccimp_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 34,
    parameter int QUO_W = 27,
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num [LANES],
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo [LANES],
    output logic [TAG_W-1:0] out_tag
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic             valid_reg [QUO_W];
    logic [NUM_W-1:0] rem_reg   [QUO_W][LANES];
    logic [QUO_W-1:0] quo_reg   [QUO_W][LANES];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [TAG_W-1:0] tag_reg   [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - s;

        logic             v_in;
        logic [NUM_W-1:0] r_in   [LANES];
        logic [QUO_W-1:0] q_in   [LANES];
        logic [DEN_W-1:0] d_in;
        logic [TAG_W-1:0] t_in;
        logic [NUM_W-1:0] r_next [LANES];
        logic [QUO_W-1:0] q_next [LANES];

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = num;
            assign d_in = den;
            assign t_in = tag;
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    q_in[l] = '0;
                end
            end
        end
        else
        begin : g_next
            assign v_in = valid_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign q_in = quo_reg[s-1];
            assign d_in = den_reg[s-1];
            assign t_in = tag_reg[s-1];
        end

        always_comb
        begin
            logic [CMP_W-1:0] dsh;
            logic [CMP_W-1:0] rext;
            dsh = CMP_W'(d_in) << BIT;
            for (int l = 0; l < LANES; l++)
            begin
                rext = CMP_W'(r_in[l]);
                if (rext >= dsh)
                begin
                    r_next[l] = NUM_W'(rext - dsh);
                    q_next[l] = q_in[l] | (QUO_W'(1) << BIT);
                end
                else
                begin
                    r_next[l] = r_in[l];
                    q_next[l] = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= r_next;
            quo_reg[s] <= q_next;
            den_reg[s] <= d_in;
            tag_reg[s] <= t_in;
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

// ===== design/ccimp_geom.sv =====
// Geometry front end: offsets, squared distance, overlap test, closing term and impulse numerators.
module ccimp_geom (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [ccimp_pkg::POS_W-1:0] a_pos_x,
    input  logic signed [ccimp_pkg::POS_W-1:0] a_pos_y,
    input  logic signed [ccimp_pkg::VEL_W-1:0] a_vel_x,
    input  logic signed [ccimp_pkg::VEL_W-1:0] a_vel_y,
    input  logic [ccimp_pkg::RAD_W-1:0]        a_radius,
    input  logic [ccimp_pkg::MASS_W-1:0]       a_mass,
    input  logic signed [ccimp_pkg::POS_W-1:0] b_pos_x,
    input  logic signed [ccimp_pkg::POS_W-1:0] b_pos_y,
    input  logic signed [ccimp_pkg::VEL_W-1:0] b_vel_x,
    input  logic signed [ccimp_pkg::VEL_W-1:0] b_vel_y,
    input  logic [ccimp_pkg::RAD_W-1:0]        b_radius,
    input  logic [ccimp_pkg::MASS_W-1:0]       b_mass,
    input  logic [ccimp_pkg::REST_W-1:0]       restitution,
    output logic                               out_valid,
    output logic [ccimp_pkg::P_W-1:0]          num_x,
    output logic [ccimp_pkg::P_W-1:0]          num_y,
    output logic [ccimp_pkg::RSQ_W-1:0]        den,
    output ccimp_pkg::tag_t                    tag
);

    // stage 1: differences and sums
    logic                                 v1_reg;
    logic signed [ccimp_pkg::DIFF_W-1:0]  dx1_reg, dy1_reg;
    logic signed [ccimp_pkg::RV_W-1:0]    rvx1_reg, rvy1_reg;
    logic [ccimp_pkg::SUM_W-1:0]          rsum1_reg;
    logic [ccimp_pkg::EP_W-1:0]           ep1_reg;
    ccimp_pkg::tag_t                      t1_reg, t1_next;

    // stage 2: products
    logic                                 v2_reg;
    logic [ccimp_pkg::SQ_W-1:0]           dxx2_reg, dyy2_reg;
    logic [ccimp_pkg::RSQ_W-1:0]          rsq2_reg;
    logic signed [ccimp_pkg::KP_W-1:0]    kx2_reg, ky2_reg;
    logic signed [ccimp_pkg::OVL_W-1:0]   dxs2_reg, dys2_reg;
    logic [ccimp_pkg::EP_W-1:0]           ep2_reg;
    ccimp_pkg::tag_t                      t2_reg;
    logic signed [ccimp_pkg::SQP_W-1:0]   sqx_next, sqy_next;
    logic signed [ccimp_pkg::KP_W-1:0]    kx_next, ky_next;

    // stage 3: sums and compare
    logic                                 v3_reg;
    logic [ccimp_pkg::RSQ_W-1:0]          den3_reg;
    logic                                 nz3_reg;
    logic signed [ccimp_pkg::K_W-1:0]     k3_reg;
    logic [ccimp_pkg::ABS_W-1:0]          adx3_reg, ady3_reg;
    logic [ccimp_pkg::EP_W-1:0]           ep3_reg;
    ccimp_pkg::tag_t                      t3_reg, t3_next;
    logic [ccimp_pkg::DIST_W-1:0]         dist_next;
    logic signed [ccimp_pkg::OVL_W-1:0]   ndx_next, ndy_next;

    // stage 4: impulse magnitude
    logic                                 v4_reg;
    logic [ccimp_pkg::G_W-1:0]            g4_reg, g_next;
    logic [ccimp_pkg::RSQ_W-1:0]          den4_reg;
    logic [ccimp_pkg::ABS_W-1:0]          adx4_reg, ady4_reg;
    ccimp_pkg::tag_t                      t4_reg, t4_next;
    logic signed [ccimp_pkg::K_W-1:0]     negk_next;

    // stage 5: numerators
    logic                                 v5_reg;
    logic [ccimp_pkg::P_W-1:0]            px5_reg, py5_reg;
    logic [ccimp_pkg::RSQ_W-1:0]          den5_reg;
    ccimp_pkg::tag_t                      t5_reg;

    always_comb
    begin
        t1_next       = '0;
        t1_next.avx   = a_vel_x;
        t1_next.avy   = a_vel_y;
        t1_next.bvx   = b_vel_x;
        t1_next.bvy   = b_vel_y;
        t1_next.am    = a_mass;
        t1_next.bm    = b_mass;
        t1_next.msum  = {1'b0, a_mass} + {1'b0, b_mass};
    end

    always_comb
    begin
        sqx_next = dx1_reg * dx1_reg;
        sqy_next = dy1_reg * dy1_reg;
        kx_next  = rvx1_reg * $signed(dx1_reg[ccimp_pkg::OVL_W-1:0]);
        ky_next  = rvy1_reg * $signed(dy1_reg[ccimp_pkg::OVL_W-1:0]);
    end

    always_comb
    begin
        dist_next = {1'b0, dxx2_reg} + {1'b0, dyy2_reg};
        ndx_next  = -dxs2_reg;
        ndy_next  = -dys2_reg;
        t3_next       = t2_reg;
        t3_next.ovl   = dist_next <= ccimp_pkg::DIST_W'(rsq2_reg);
        t3_next.sgn_x = dxs2_reg[ccimp_pkg::OVL_W-1];
        t3_next.sgn_y = dys2_reg[ccimp_pkg::OVL_W-1];
    end

    always_comb
    begin
        negk_next = -k3_reg;
        g_next    = ep3_reg * negk_next[ccimp_pkg::KMAG_W-1:0];
        t4_next     = t3_reg;
        t4_next.app = t3_reg.ovl && nz3_reg && (t3_reg.am != '0) && (t3_reg.bm != '0)
                      && k3_reg[ccimp_pkg::K_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg   <= {a_pos_x[ccimp_pkg::POS_W-1], a_pos_x} - {b_pos_x[ccimp_pkg::POS_W-1], b_pos_x};
        dy1_reg   <= {a_pos_y[ccimp_pkg::POS_W-1], a_pos_y} - {b_pos_y[ccimp_pkg::POS_W-1], b_pos_y};
        rvx1_reg  <= {a_vel_x[ccimp_pkg::VEL_W-1], a_vel_x} - {b_vel_x[ccimp_pkg::VEL_W-1], b_vel_x};
        rvy1_reg  <= {a_vel_y[ccimp_pkg::VEL_W-1], a_vel_y} - {b_vel_y[ccimp_pkg::VEL_W-1], b_vel_y};
        rsum1_reg <= {1'b0, a_radius} + {1'b0, b_radius};
        ep1_reg   <= ccimp_pkg::ONE_Q8 + {1'b0, restitution};
        t1_reg    <= t1_next;

        dxx2_reg <= sqx_next[ccimp_pkg::SQ_W-1:0];
        dyy2_reg <= sqy_next[ccimp_pkg::SQ_W-1:0];
        rsq2_reg <= rsum1_reg * rsum1_reg;
        kx2_reg  <= kx_next;
        ky2_reg  <= ky_next;
        dxs2_reg <= dx1_reg[ccimp_pkg::OVL_W-1:0];
        dys2_reg <= dy1_reg[ccimp_pkg::OVL_W-1:0];
        ep2_reg  <= ep1_reg;
        t2_reg   <= t1_reg;

        den3_reg <= dist_next[ccimp_pkg::RSQ_W-1:0];
        nz3_reg  <= dist_next != '0;
        k3_reg   <= {kx2_reg[ccimp_pkg::KP_W-1], kx2_reg} + {ky2_reg[ccimp_pkg::KP_W-1], ky2_reg};
        adx3_reg <= dxs2_reg[ccimp_pkg::OVL_W-1] ? ndx_next[ccimp_pkg::ABS_W-1:0]
                                                 : dxs2_reg[ccimp_pkg::ABS_W-1:0];
        ady3_reg <= dys2_reg[ccimp_pkg::OVL_W-1] ? ndy_next[ccimp_pkg::ABS_W-1:0]
                                                 : dys2_reg[ccimp_pkg::ABS_W-1:0];
        ep3_reg  <= ep2_reg;
        t3_reg   <= t3_next;

        g4_reg   <= g_next;
        den4_reg <= den3_reg;
        adx4_reg <= adx3_reg;
        ady4_reg <= ady3_reg;
        t4_reg   <= t4_next;

        px5_reg  <= g4_reg * adx4_reg;
        py5_reg  <= g4_reg * ady4_reg;
        den5_reg <= den4_reg;
        t5_reg   <= t4_reg;
    end

    assign out_valid = v5_reg;
    assign num_x     = px5_reg;
    assign num_y     = py5_reg;
    assign den       = den5_reg;
    assign tag       = t5_reg;

    // an impulse is only ever flagged on an overlapping pair
    a_app_ovl: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && t4_reg.app |-> t4_reg.ovl)
        else $error("impulse flagged without overlap");

endmodule
